### src/vdp_pkg.sv
package vdp_pkg;

  // Default sizes of the block (top-level parameter defaults)
  localparam int MAX_PLANES_DEF = 8;
  localparam int MAX_PITCH_DEF  = 256;
  localparam int MAX_ROWS_DEF   = 1024;
  localparam int QUEUE_DEPTH    = 4;

  // Fixed field widths
  localparam int DATA_W       = 8;
  localparam int PLANE_W      = 3;
  localparam int REP_W        = 8;
  localparam int OFFSET_W     = 21;
  localparam int PITCH_REG_W  = 9;
  localparam int PLANES_REG_W = 4;
  localparam int ROWS_REG_W   = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_PITCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PLANES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS  = 2'd2;

  // Configuration reset values
  localparam logic [PITCH_REG_W-1:0]  PITCH_RST  = 9'd40;
  localparam logic [PLANES_REG_W-1:0] PLANES_RST = 4'd5;
  localparam logic [ROWS_REG_W-1:0]   ROWS_RST   = 11'd200;

  localparam int PITCH_MIN = 2;

  // Op code layout: bit 7 marks a literal copy, low 7 bits give its length
  localparam int OP_COPY_BIT = 7;
  localparam int COPY_LEN_W  = 7;

  // Op codes
  localparam logic [DATA_W-1:0] OP_FILL      = 8'h00;
  localparam logic [DATA_W-1:0] OP_COPY_FLAG = 8'h80;

  typedef struct packed {
    logic write_valid;
    logic out_of_range;
    logic plane_done;
  } vdp_flags_t;

endpackage

### src/vdp_queue.sv
module vdp_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_vld,
  output logic         push_rdy,
  input  logic [W-1:0] push_data,
  output logic         pop_vld,
  input  logic         pop_rdy,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [W-1:0]     pop_data_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_rdy = (count_r != CNT_W'(DEPTH));
  assign pop_vld  = (count_r != '0);
  assign pop_data = pop_data_r;
  assign push     = push_vld && push_rdy;
  assign pop      = pop_vld && pop_rdy;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Keep the head entry registered; forward the incoming word when it lands there
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      pop_data_r <= push_data;
    end else begin
      pop_data_r <= mem[rd_ptr_nxt];
    end
  end

endmodule

### src/vdp_front.sv
module vdp_front #(
  parameter int MAX_PLANES = vdp_pkg::MAX_PLANES_DEF,
  parameter int MAX_PITCH  = vdp_pkg::MAX_PITCH_DEF,
  parameter int MAX_ROWS   = vdp_pkg::MAX_ROWS_DEF,
  localparam int EP_W  = $clog2(MAX_PITCH + 1),
  localparam int EPL_W = $clog2(MAX_PLANES + 1),
  localparam int ROW_W = $clog2(MAX_ROWS + 1),
  localparam int COL_W = $clog2(MAX_PITCH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [vdp_pkg::DATA_W-1:0]  in_data_byte,
  input  logic                        in_plane_start,
  input  logic [vdp_pkg::PLANE_W-1:0] in_plane_number,
  input  logic [EP_W-1:0]             eff_pitch,
  input  logic [EPL_W-1:0]            eff_planes,
  input  logic [ROW_W-1:0]            eff_rows,
  output logic                        q_vld,
  input  logic                        q_rdy,
  output vdp_pkg::vdp_flags_t         q_flags,
  output logic [vdp_pkg::DATA_W-1:0]  q_value,
  output logic [vdp_pkg::REP_W-1:0]   q_rep,
  output logic [ROW_W-1:0]            q_row,
  output logic [COL_W-1:0]            q_col,
  output logic [vdp_pkg::PLANE_W-1:0] q_plane
);

  localparam int SUM_W = ((ROW_W > vdp_pkg::DATA_W) ? ROW_W : vdp_pkg::DATA_W) + 1;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_OPCOUNT   = 6'b000010,
    PH_OPCODE    = 6'b000100,
    PH_FILLCOUNT = 6'b001000,
    PH_FILLVALUE = 6'b010000,
    PH_COPY      = 6'b100000
  } phase_t;

  phase_t                            phase_r, phase_nxt, cur_phase;
  logic [vdp_pkg::DATA_W-1:0]        ops_r, ops_nxt, ops_dec;
  logic [vdp_pkg::COPY_LEN_W-1:0]    copy_r, copy_nxt, copy_dec;
  logic [vdp_pkg::DATA_W-1:0]        fill_r, fill_nxt;
  logic [COL_W-1:0]                  col_r, col_nxt, cur_col;
  logic [ROW_W-1:0]                  row_r, row_nxt, cur_row, adv_row;
  logic [vdp_pkg::PLANE_W-1:0]       plane_r, plane_nxt, cur_plane;
  logic [vdp_pkg::DATA_W-1:0]        adv_n;
  logic [SUM_W-1:0]                  adv_sum;
  logic [COL_W:0]                    col_inc;
  logic                              fire, plane_ok, row_past, rows_over, col_last;
  logic                              op_end, col_end;

  assign q_vld    = in_valid;
  assign in_ready = q_rdy;
  assign fire     = in_valid && q_rdy;

  // A plane start restarts at column 0, row 0 of the new plane
  assign cur_phase = in_plane_start ? PH_OPCOUNT : phase_r;
  assign cur_col   = in_plane_start ? '0 : col_r;
  assign cur_row   = in_plane_start ? '0 : row_r;
  assign cur_plane = in_plane_start ? in_plane_number : plane_r;

  assign plane_ok = (32'(cur_plane) < 32'(eff_planes));

  // Row advance, saturating at the frame height
  always_comb begin
    case (cur_phase)
      PH_FILLVALUE: adv_n = fill_r;
      PH_COPY:      adv_n = vdp_pkg::DATA_W'(1);
      default:      adv_n = in_data_byte;
    endcase
  end

  assign adv_sum   = SUM_W'(cur_row) + SUM_W'(adv_n);
  assign rows_over = (adv_sum > SUM_W'(eff_rows));
  assign adv_row   = rows_over ? eff_rows : adv_sum[ROW_W-1:0];
  assign row_past  = (cur_row >= eff_rows);

  assign col_inc  = {1'b0, cur_col} + (COL_W + 1)'(1);
  assign col_last = (32'(col_inc) >= 32'(eff_pitch));
  assign ops_dec  = (ops_r != '0) ? ops_r - vdp_pkg::DATA_W'(1) : '0;
  assign copy_dec = (copy_r != '0) ? copy_r - vdp_pkg::COPY_LEN_W'(1) : '0;

  always_comb begin
    phase_nxt = phase_r;
    ops_nxt   = ops_r;
    copy_nxt  = copy_r;
    fill_nxt  = fill_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    q_flags   = '0;
    q_value   = '0;
    q_rep     = '0;
    q_row     = cur_row;
    q_col     = cur_col;
    q_plane   = cur_plane;
    op_end    = 1'b0;
    col_end   = 1'b0;
    if (fire) begin
      if (in_plane_start) begin
        plane_nxt = in_plane_number;
        col_nxt   = '0;
        row_nxt   = '0;
        copy_nxt  = '0;
        fill_nxt  = '0;
        phase_nxt = PH_OPCOUNT;
      end
      case (cur_phase)
        PH_IDLE: begin
        end
        PH_OPCOUNT: begin
          ops_nxt = in_data_byte;
          if (in_data_byte == '0) begin
            col_end = 1'b1;
          end else begin
            phase_nxt = PH_OPCODE;
          end
        end
        PH_OPCODE: begin
          if (in_data_byte == vdp_pkg::OP_FILL) begin
            phase_nxt = PH_FILLCOUNT;
          end else if (in_data_byte[vdp_pkg::OP_COPY_BIT]) begin
            copy_nxt = in_data_byte[vdp_pkg::COPY_LEN_W-1:0];
            if (in_data_byte[vdp_pkg::COPY_LEN_W-1:0] == '0) begin
              op_end = 1'b1;
            end else begin
              phase_nxt = PH_COPY;
            end
          end else begin
            row_nxt = adv_row;
            op_end  = 1'b1;
          end
        end
        PH_FILLCOUNT: begin
          fill_nxt  = in_data_byte;
          phase_nxt = PH_FILLVALUE;
        end
        PH_FILLVALUE: begin
          if (fill_r != '0) begin
            if (!plane_ok || rows_over) begin
              q_flags.out_of_range = 1'b1;
            end else begin
              q_flags.write_valid = 1'b1;
              q_value             = in_data_byte;
              q_rep               = fill_r;
            end
            row_nxt = adv_row;
          end
          op_end = 1'b1;
        end
        PH_COPY: begin
          if (!plane_ok || row_past) begin
            q_flags.out_of_range = 1'b1;
          end else begin
            q_flags.write_valid = 1'b1;
            q_value             = in_data_byte;
            q_rep               = vdp_pkg::REP_W'(1);
          end
          row_nxt  = adv_row;
          copy_nxt = copy_dec;
          if (copy_dec == '0) begin
            op_end = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      if (op_end) begin
        if (ops_dec == '0) begin
          col_end = 1'b1;
        end else begin
          ops_nxt   = ops_dec;
          phase_nxt = PH_OPCODE;
        end
      end
      if (col_end) begin
        row_nxt  = '0;
        ops_nxt  = '0;
        copy_nxt = '0;
        if (col_last) begin
          phase_nxt          = PH_IDLE;
          col_nxt            = '0;
          q_flags.plane_done = 1'b1;
        end else begin
          phase_nxt = PH_OPCOUNT;
          col_nxt   = col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ops_r   <= '0;
      copy_r  <= '0;
      fill_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      ops_r   <= ops_nxt;
      copy_r  <= copy_nxt;
      fill_r  <= fill_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
    end
  end

endmodule

### src/vdp_back.sv
module vdp_back #(
  parameter int MAX_PLANES = vdp_pkg::MAX_PLANES_DEF,
  parameter int MAX_PITCH  = vdp_pkg::MAX_PITCH_DEF,
  parameter int MAX_ROWS   = vdp_pkg::MAX_ROWS_DEF,
  localparam int EP_W  = $clog2(MAX_PITCH + 1),
  localparam int EPL_W = $clog2(MAX_PLANES + 1),
  localparam int ROW_W = $clog2(MAX_ROWS + 1),
  localparam int COL_W = $clog2(MAX_PITCH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  output logic                         in_rdy,
  input  vdp_pkg::vdp_flags_t          in_flags,
  input  logic [vdp_pkg::DATA_W-1:0]   in_value,
  input  logic [vdp_pkg::REP_W-1:0]    in_rep,
  input  logic [ROW_W-1:0]             in_row,
  input  logic [COL_W-1:0]             in_col,
  input  logic [vdp_pkg::PLANE_W-1:0]  in_plane,
  input  logic [EP_W-1:0]              eff_pitch,
  input  logic [EPL_W-1:0]             eff_planes,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_write_valid,
  output logic [vdp_pkg::OFFSET_W-1:0] out_write_offset,
  output logic [vdp_pkg::DATA_W-1:0]   out_write_value,
  output logic [vdp_pkg::REP_W-1:0]    out_repeat_count,
  output logic                         out_plane_done,
  output logic                         out_out_of_range
);

  localparam int STRIDE_W = $clog2(MAX_PITCH * MAX_PLANES + 1);
  localparam int BASE_W   = $clog2(8 * MAX_PITCH);
  localparam int PROD_W   = ROW_W + STRIDE_W;
  localparam int MAX_PB   = (PROD_W > BASE_W) ? PROD_W : BASE_W;
  localparam int OSUM_W   = ((MAX_PB > vdp_pkg::OFFSET_W) ? MAX_PB : vdp_pkg::OFFSET_W) + 1;

  // Stage 1: row stride and in-row base offset
  logic                         s1_vld_r;
  vdp_pkg::vdp_flags_t          s1_flags_r;
  logic [vdp_pkg::DATA_W-1:0]   s1_value_r;
  logic [vdp_pkg::REP_W-1:0]    s1_rep_r;
  logic [ROW_W-1:0]             s1_row_r;
  logic [STRIDE_W-1:0]          s1_stride_r, s1_stride_nxt;
  logic [BASE_W-1:0]            s1_base_r, s1_base_nxt;

  // Stage 2: output register
  logic                         o_vld_r;
  vdp_pkg::vdp_flags_t          o_flags_r;
  logic [vdp_pkg::DATA_W-1:0]   o_value_r;
  logic [vdp_pkg::REP_W-1:0]    o_rep_r;
  logic [vdp_pkg::OFFSET_W-1:0] o_offset_r, o_offset_nxt;
  logic [OSUM_W-1:0]            off_sum;
  logic                         o_rdy;

  assign o_rdy  = !o_vld_r || out_ready;
  assign in_rdy = !s1_vld_r || o_rdy;

  assign s1_stride_nxt = STRIDE_W'(eff_pitch) * STRIDE_W'(eff_planes);
  assign s1_base_nxt   = BASE_W'(in_plane) * BASE_W'(eff_pitch) + BASE_W'(in_col);

  assign off_sum      = OSUM_W'(s1_row_r) * OSUM_W'(s1_stride_r) + OSUM_W'(s1_base_r);
  assign o_offset_nxt = s1_flags_r.write_valid ? off_sum[vdp_pkg::OFFSET_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      if (in_rdy) begin
        s1_vld_r <= in_vld;
      end
      if (o_rdy) begin
        o_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && in_rdy) begin
      s1_flags_r  <= in_flags;
      s1_value_r  <= in_value;
      s1_rep_r    <= in_rep;
      s1_row_r    <= in_row;
      s1_stride_r <= s1_stride_nxt;
      s1_base_r   <= s1_base_nxt;
    end
    if (s1_vld_r && o_rdy) begin
      o_flags_r  <= s1_flags_r;
      o_value_r  <= s1_value_r;
      o_rep_r    <= s1_rep_r;
      o_offset_r <= o_offset_nxt;
    end
  end

  assign out_valid        = o_vld_r;
  assign out_write_valid  = o_flags_r.write_valid;
  assign out_write_offset = o_offset_r;
  assign out_write_value  = o_value_r;
  assign out_repeat_count = o_rep_r;
  assign out_plane_done   = o_flags_r.plane_done;
  assign out_out_of_range = o_flags_r.out_of_range;

endmodule

### src/vertical_delta_plane_decoder.sv
// Vertical byte-delta plane decoder. Feed the op list of one bitplane a byte
// per transaction, with plane_start high on the first byte (the op count of
// column 0) and plane_number naming the plane. Each accepted byte yields
// exactly one result transaction: either a write descriptor (offset, value,
// repeat count down the column at stride plane_pitch * num_planes) or an
// empty result, with plane_done marking the byte that finishes the last
// column and out_of_range marking a write suppressed because it would pass
// the frame height or names a plane beyond num_planes. The block sustains
// one byte per clock while the queue has room; the front decodes a byte into
// the queue in the accepting cycle, and its result then passes from the queue
// through the back's registers for the stride/base products and for the
// offset multiply-add. The decode front hands classified ops through a
// four-entry queue to the address back end, so a stalled result port only
// stops input once that queue fills.
// Configuration registers are written through the cfg port, which is always
// ready; write them only while no transaction is in flight.
module vertical_delta_plane_decoder #(
  parameter int MAX_PLANES = vdp_pkg::MAX_PLANES_DEF,
  parameter int MAX_PITCH  = vdp_pkg::MAX_PITCH_DEF,
  parameter int MAX_ROWS   = vdp_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vdp_pkg::DATA_W-1:0]     in_data_byte,
  input  logic                           in_plane_start,
  input  logic [vdp_pkg::PLANE_W-1:0]    in_plane_number,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_write_valid,
  output logic [vdp_pkg::OFFSET_W-1:0]   out_write_offset,
  output logic [vdp_pkg::DATA_W-1:0]     out_write_value,
  output logic [vdp_pkg::REP_W-1:0]      out_repeat_count,
  output logic                           out_plane_done,
  output logic                           out_out_of_range,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vdp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int EP_W  = $clog2(MAX_PITCH + 1);
  localparam int EPL_W = $clog2(MAX_PLANES + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int COL_W = $clog2(MAX_PITCH);
  localparam int Q_W   = $bits(vdp_pkg::vdp_flags_t) + vdp_pkg::DATA_W + vdp_pkg::REP_W
                         + ROW_W + COL_W + vdp_pkg::PLANE_W;

  // Configuration registers, raw as written
  logic [vdp_pkg::PITCH_REG_W-1:0]  plane_pitch_r;
  logic [vdp_pkg::PLANES_REG_W-1:0] num_planes_r;
  logic [vdp_pkg::ROWS_REG_W-1:0]   frame_rows_r;

  // Effective (saturated) configuration
  logic [EP_W-1:0]  eff_pitch;
  logic [EPL_W-1:0] eff_planes;
  logic [ROW_W-1:0] eff_rows;

  // Front to queue
  logic                        f_vld, f_rdy;
  vdp_pkg::vdp_flags_t         f_flags;
  logic [vdp_pkg::DATA_W-1:0]  f_value;
  logic [vdp_pkg::REP_W-1:0]   f_rep;
  logic [ROW_W-1:0]            f_row;
  logic [COL_W-1:0]            f_col;
  logic [vdp_pkg::PLANE_W-1:0] f_plane;

  // Queue to back
  logic                        b_vld, b_rdy;
  vdp_pkg::vdp_flags_t         b_flags;
  logic [vdp_pkg::DATA_W-1:0]  b_value;
  logic [vdp_pkg::REP_W-1:0]   b_rep;
  logic [ROW_W-1:0]            b_row;
  logic [COL_W-1:0]            b_col;
  logic [vdp_pkg::PLANE_W-1:0] b_plane;
  logic [Q_W-1:0]              q_din, q_dout;

  assign cfg_ready = 1'b1;

  // Writes to an index beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_pitch_r <= vdp_pkg::PITCH_RST;
      num_planes_r  <= vdp_pkg::PLANES_RST;
      frame_rows_r  <= vdp_pkg::ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vdp_pkg::CFG_PLANE_PITCH: plane_pitch_r <= cfg_data[vdp_pkg::PITCH_REG_W-1:0];
        vdp_pkg::CFG_NUM_PLANES:  num_planes_r  <= cfg_data[vdp_pkg::PLANES_REG_W-1:0];
        vdp_pkg::CFG_FRAME_ROWS:  frame_rows_r  <= cfg_data[vdp_pkg::ROWS_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Saturate the registers into their legal ranges
  assign eff_pitch = (32'(plane_pitch_r) < 32'(vdp_pkg::PITCH_MIN)) ? EP_W'(vdp_pkg::PITCH_MIN) :
                     (32'(plane_pitch_r) > 32'(MAX_PITCH))          ? EP_W'(MAX_PITCH) :
                                                                      EP_W'(plane_pitch_r);
  assign eff_planes = (num_planes_r == '0)                        ? EPL_W'(1) :
                      (32'(num_planes_r) > 32'(MAX_PLANES))       ? EPL_W'(MAX_PLANES) :
                                                                    EPL_W'(num_planes_r);
  assign eff_rows = (frame_rows_r == '0)                          ? ROW_W'(1) :
                    (32'(frame_rows_r) > 32'(MAX_ROWS))           ? ROW_W'(MAX_ROWS) :
                                                                    ROW_W'(frame_rows_r);

  // Front: op stream parser, one byte per cycle while the queue accepts
  vdp_front #(
    .MAX_PLANES (MAX_PLANES),
    .MAX_PITCH  (MAX_PITCH),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_plane_start  (in_plane_start),
    .in_plane_number (in_plane_number),
    .eff_pitch       (eff_pitch),
    .eff_planes      (eff_planes),
    .eff_rows        (eff_rows),
    .q_vld           (f_vld),
    .q_rdy           (f_rdy),
    .q_flags         (f_flags),
    .q_value         (f_value),
    .q_rep           (f_rep),
    .q_row           (f_row),
    .q_col           (f_col),
    .q_plane         (f_plane)
  );

  // Hold decoded ops between front and back
  assign q_din = {f_flags, f_value, f_rep, f_row, f_col, f_plane};
  assign {b_flags, b_value, b_rep, b_row, b_col, b_plane} = q_dout;

  vdp_queue #(
    .W     (Q_W),
    .DEPTH (vdp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (f_vld),
    .push_rdy  (f_rdy),
    .push_data (q_din),
    .pop_vld   (b_vld),
    .pop_rdy   (b_rdy),
    .pop_data  (q_dout)
  );

  // Back: buffer offset computation and result register
  vdp_back #(
    .MAX_PLANES (MAX_PLANES),
    .MAX_PITCH  (MAX_PITCH),
    .MAX_ROWS   (MAX_ROWS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_vld           (b_vld),
    .in_rdy           (b_rdy),
    .in_flags         (b_flags),
    .in_value         (b_value),
    .in_rep           (b_rep),
    .in_row           (b_row),
    .in_col           (b_col),
    .in_plane         (b_plane),
    .eff_pitch        (eff_pitch),
    .eff_planes       (eff_planes),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_valid  (out_write_valid),
    .out_write_offset (out_write_offset),
    .out_write_value  (out_write_value),
    .out_repeat_count (out_repeat_count),
    .out_plane_done   (out_plane_done),
    .out_out_of_range (out_out_of_range)
  );

endmodule

### src/vdp_checker.sv
module vdp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_write_valid,
  input logic [vdp_pkg::OFFSET_W-1:0] out_write_offset,
  input logic [vdp_pkg::DATA_W-1:0]   out_write_value,
  input logic [vdp_pkg::REP_W-1:0]    out_repeat_count,
  input logic                         out_out_of_range
);

  // Results are dropped by reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_offset)
      && $stable(out_write_value) && $stable(out_repeat_count))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |->
      out_write_offset == '0 && out_write_value == '0 && out_repeat_count == '0)
    else $error("empty result carries nonzero payload");

  a_write_not_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid |-> !out_out_of_range && out_repeat_count != '0)
    else $error("write descriptor flagged or empty");

endmodule

bind vertical_delta_plane_decoder vdp_checker u_vdp_checker (.*);

### sim/vertical_delta_plane_decoder_test.sv
module vertical_delta_plane_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Run bounds: even under heavy stalls, the limit leaves a wide margin over
  // about 1100 bytes.
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 12;   // pipeline is three deep; drain a bit more
  localparam int SEG_BYTES   = 150;  // random bytes per configuration segment
  localparam int REPORT_MAX  = 10;

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_OP_COUNT   = 6'b000010,
    PH_OP_CODE    = 6'b000100,
    PH_FILL_COUNT = 6'b001000,
    PH_FILL_VALUE = 6'b010000,
    PH_COPY       = 6'b100000
  } decode_phase_t;

  // Handshake pacing: slow sink, slow source, then free running
  typedef enum int { PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FREE } pace_t;

  typedef struct packed {
    logic [vdp_pkg::DATA_W-1:0]  data;
    logic                        start;
    logic [vdp_pkg::PLANE_W-1:0] plane;
  } op_byte_t;

  typedef struct packed {
    logic                         wr_valid;
    logic [vdp_pkg::OFFSET_W-1:0] offset;
    logic [vdp_pkg::DATA_W-1:0]   value;
    logic [vdp_pkg::REP_W-1:0]    repeats;
    logic                         done;
    logic                         oor;
  } plane_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [vdp_pkg::DATA_W-1:0]     in_data_byte = '0;
  logic                           in_plane_start = 1'b0;
  logic [vdp_pkg::PLANE_W-1:0]    in_plane_number = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_write_valid;
  logic [vdp_pkg::OFFSET_W-1:0]   out_write_offset;
  logic [vdp_pkg::DATA_W-1:0]     out_write_value;
  logic [vdp_pkg::REP_W-1:0]      out_repeat_count;
  logic                           out_plane_done;
  logic                           out_out_of_range;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [vdp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [vdp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  vertical_delta_plane_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_plane_start   (in_plane_start),
    .in_plane_number  (in_plane_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_valid  (out_write_valid),
    .out_write_offset (out_write_offset),
    .out_write_value  (out_write_value),
    .out_repeat_count (out_repeat_count),
    .out_plane_done   (out_plane_done),
    .out_out_of_range (out_out_of_range),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  // Stimulus and scoreboard state
  op_byte_t     pending_bytes[$];
  plane_write_t expected_writes[$];
  op_byte_t     cur_item;
  int           in_flight = 0;      // bytes queued whose result has not been checked
  int           queued_bytes = 0;   // bytes handed to the driver so far
  int           mismatches = 0;
  int           cycle_count = 0;
  pace_t        pace = PACE_SLOW_SINK;

  // Shadow of the configuration registers, raw as written
  logic [vdp_pkg::PITCH_REG_W-1:0]  pitch_reg  = vdp_pkg::PITCH_RST;
  logic [vdp_pkg::PLANES_REG_W-1:0] planes_reg = vdp_pkg::PLANES_RST;
  logic [vdp_pkg::ROWS_REG_W-1:0]   rows_reg   = vdp_pkg::ROWS_RST;

  // Shadow of the decoder state
  decode_phase_t               phase = PH_IDLE;
  logic [7:0]                  ops_left = '0;
  logic [6:0]                  copy_left = '0;
  logic [7:0]                  fill_len = '0;
  logic [8:0]                  col = '0;      // one bit wider so the pitch compare holds at 256
  logic [10:0]                 row = '0;
  logic [vdp_pkg::PLANE_W-1:0] cur_plane = '0;

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int eff_pitch();
    return clamp(int'(pitch_reg), vdp_pkg::PITCH_MIN, vdp_pkg::MAX_PITCH_DEF);
  endfunction

  function automatic int eff_planes();
    return clamp(int'(planes_reg), 1, vdp_pkg::MAX_PLANES_DEF);
  endfunction

  function automatic int eff_rows();
    return clamp(int'(rows_reg), 1, vdp_pkg::MAX_ROWS_DEF);
  endfunction

  // Move down the column; the row position saturates at the frame height.
  function automatic void step_rows(int n);
    int r;
    r = int'(row) + n;
    row = 11'((r > eff_rows()) ? eff_rows() : r);
  endfunction

  // Close the current column; return 1 when it was the plane's last one.
  function automatic logic finish_column();
    col = col + 9'd1;
    row = '0;
    ops_left = '0;
    copy_left = '0;
    if (int'(col) >= eff_pitch()) begin
      phase = PH_IDLE;
      col = '0;
      return 1'b1;
    end
    phase = PH_OP_COUNT;
    return 1'b0;
  endfunction

  function automatic logic finish_op();
    if (ops_left != 0) ops_left = ops_left - 8'd1;
    if (ops_left == 0) return finish_column();
    phase = PH_OP_CODE;
    return 1'b0;
  endfunction

  function automatic logic [vdp_pkg::OFFSET_W-1:0] buffer_offset();
    int p;
    int o;
    p = eff_pitch();
    o = int'(row) * p * eff_planes() + int'(cur_plane) * p + int'(col);
    return o[vdp_pkg::OFFSET_W-1:0];
  endfunction

  // Decode one op-stream byte into the write it causes.
  function automatic plane_write_t decode_byte(op_byte_t it);
    plane_write_t w;
    logic         plane_ok;
    w = '0;
    if (it.start) begin
      cur_plane = it.plane;
      col = '0;
      row = '0;
      copy_left = '0;
      fill_len = '0;
      phase = PH_OP_COUNT;
    end
    plane_ok = int'(cur_plane) < eff_planes();
    case (phase)
      PH_OP_COUNT: begin
        ops_left = it.data;
        if (it.data == 0) w.done = finish_column();
        else phase = PH_OP_CODE;
      end
      PH_OP_CODE: begin
        if (it.data == vdp_pkg::OP_FILL) begin
          phase = PH_FILL_COUNT;
        end else if (it.data[vdp_pkg::OP_COPY_BIT]) begin
          copy_left = it.data[vdp_pkg::COPY_LEN_W-1:0];
          if (copy_left == 0) w.done = finish_op();
          else phase = PH_COPY;
        end else begin
          step_rows(int'(it.data));
          w.done = finish_op();
        end
      end
      PH_FILL_COUNT: begin
        fill_len = it.data;
        phase = PH_FILL_VALUE;
      end
      PH_FILL_VALUE: begin
        if (fill_len != 0) begin
          if (!plane_ok || int'(row) + int'(fill_len) > eff_rows()) begin
            w.oor = 1'b1;
          end else begin
            w.wr_valid = 1'b1;
            w.offset = buffer_offset();
            w.value = it.data;
            w.repeats = fill_len;
          end
          step_rows(int'(fill_len));
        end
        w.done = finish_op();
      end
      PH_COPY: begin
        if (!plane_ok || int'(row) >= eff_rows()) begin
          w.oor = 1'b1;
        end else begin
          w.wr_valid = 1'b1;
          w.offset = buffer_offset();
          w.value = it.data;
          w.repeats = vdp_pkg::REP_W'(1);
        end
        step_rows(1);
        if (copy_left != 0) copy_left = copy_left - 7'd1;
        if (copy_left == 0) w.done = finish_op();
      end
      default: phase = PH_IDLE;
    endcase
    return w;
  endfunction

  function automatic logic source_idles();
    case (pace)
      PACE_SLOW_SINK:   return $urandom_range(99) < 6;
      PACE_SLOW_SOURCE: return $urandom_range(99) < 79;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic sink_stalls();
    case (pace)
      PACE_SLOW_SINK:   return $urandom_range(99) < 79;
      PACE_SLOW_SOURCE: return $urandom_range(99) < 6;
      default:          return 1'b0;
    endcase
  endfunction

  // Driver: present queued bytes, hold each until accepted, and predict the
  // result of every accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_writes.insert(expected_writes.size(), decode_byte(cur_item));
      if (pending_bytes.size() != 0 && !source_idles()) begin
        cur_item = pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= cur_item.data;
        in_plane_start <= cur_item.start;
        in_plane_number <= cur_item.plane;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    plane_write_t got;
    plane_write_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_write_valid, out_write_offset, out_write_value,
                out_repeat_count, out_plane_done, out_out_of_range};
        if (expected_writes.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: unexpected result wv=%0b off=%0h val=%0h rep=%0d done=%0b oor=%0b",
                     $realtime, got.wr_valid, got.offset, got.value, got.repeats,
                     got.done, got.oor);
          mismatches++;
        end else begin
          want = expected_writes.pop_front();
          in_flight--;
          if (got != want) begin
            if (mismatches < REPORT_MAX)
              $display({"%0t: expected wv=%0b off=%0h val=%0h rep=%0d done=%0b oor=%0b,",
                        " got wv=%0b off=%0h val=%0h rep=%0d done=%0b oor=%0b"},
                       $realtime, want.wr_valid, want.offset, want.value, want.repeats,
                       want.done, want.oor, got.wr_valid, got.offset, got.value,
                       got.repeats, got.done, got.oor);
            mismatches++;
          end
        end
      end
      out_ready <= !sink_stalls();
    end
  end

  // Watchdog: end the run, reporting mismatches, once the cycle limit is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_op(logic [vdp_pkg::DATA_W-1:0] d, logic s,
                         logic [vdp_pkg::PLANE_W-1:0] p);
    pending_bytes.insert(pending_bytes.size(), op_byte_t'{d, s, p});
    in_flight++;
    queued_bytes++;
  endtask

  // Hold until every queued byte has produced its checked result.
  task automatic wait_drained();
    do @(posedge clk); while (in_flight != 0);
  endtask

  // Write one register and mirror it in the shadow copy at the handshake.
  task automatic write_reg(logic [vdp_pkg::CFG_IDX_W-1:0] idx,
                           logic [vdp_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vdp_pkg::CFG_PLANE_PITCH: pitch_reg = val[vdp_pkg::PITCH_REG_W-1:0];
      vdp_pkg::CFG_NUM_PLANES:  planes_reg = val[vdp_pkg::PLANES_REG_W-1:0];
      vdp_pkg::CFG_FRAME_ROWS:  rows_reg = val[vdp_pkg::ROWS_REG_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // One well-formed plane with random content; may be cut short so that the
  // next plane start lands mid-list.
  task automatic gen_plane(int target);
    logic [vdp_pkg::PLANE_W-1:0] pl;
    logic                        first;
    int                          nops;
    int                          n;
    pl = ($urandom_range(7) == 0) ? vdp_pkg::PLANE_W'($urandom_range(7))
                                  : vdp_pkg::PLANE_W'($urandom_range(eff_planes() - 1));
    first = 1'b1;
    for (int c = 0; c < eff_pitch(); c++) begin
      if (queued_bytes >= target || $urandom_range(39) == 0) return;
      case ($urandom_range(15)) inside
        [0:3]:   nops = 0;
        [13:14]: nops = $urandom_range(8, 4);
        15:      nops = $urandom_range(255);
        default: nops = $urandom_range(3, 1);
      endcase
      push_op(vdp_pkg::DATA_W'(nops), first, pl);
      first = 1'b0;
      for (int k = 0; k < nops; k++) begin
        // Stop mid-column once the byte budget is spent
        if (queued_bytes >= target) return;
        case ($urandom_range(2))
          0: begin
            n = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(20);
            push_op(vdp_pkg::OP_FILL, 1'b0, pl);
            push_op(vdp_pkg::DATA_W'(n), 1'b0, pl);
            push_op(vdp_pkg::DATA_W'($urandom_range(255)), 1'b0, pl);
          end
          1: begin
            n = ($urandom_range(15) == 0) ? $urandom_range(127) : $urandom_range(5);
            push_op(vdp_pkg::OP_COPY_FLAG | vdp_pkg::DATA_W'(n), 1'b0, pl);
            for (int j = 0; j < n; j++)
              push_op(vdp_pkg::DATA_W'($urandom_range(255)), 1'b0, pl);
          end
          default: begin
            n = $urandom_range(1) ? $urandom_range(8, 1) : $urandom_range(127, 1);
            push_op(vdp_pkg::DATA_W'(n), 1'b0, pl);
          end
        endcase
      end
    end
  endtask

  task automatic gen_random(int count);
    int target;
    target = queued_bytes + count;
    while (queued_bytes < target) begin
      // Add noise now and then: a stray byte, sometimes posing as a plane start.
      if ($urandom_range(9) == 0)
        push_op(vdp_pkg::DATA_W'($urandom_range(255)), $urandom_range(7) == 0,
                vdp_pkg::PLANE_W'($urandom_range(7)));
      else
        gen_plane(target);
    end
  endtask

  // One configuration segment: pause for a full drain halfway through.
  task automatic run_segment(pace_t p, int pitch, int planes, int rows);
    wait_drained();
    pace = p;
    write_reg(vdp_pkg::CFG_PLANE_PITCH, vdp_pkg::CFG_DATA_W'(pitch));
    write_reg(vdp_pkg::CFG_NUM_PLANES, vdp_pkg::CFG_DATA_W'(planes));
    write_reg(vdp_pkg::CFG_FRAME_ROWS, vdp_pkg::CFG_DATA_W'(rows));
    gen_random(SEG_BYTES / 2);
    wait_drained();
    gen_random(SEG_BYTES / 2);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bytes at the reset configuration (pitch 40, 5 planes, 200 rows)
    push_op(8'h5A, 1'b0, 3'd0);                      // stray byte while idle
    push_op(8'd3, 1'b1, 3'd2);                       // plane 2, column 0 has three ops
    push_op(vdp_pkg::OP_FILL, 1'b0, 3'd2);
    push_op(8'd0, 1'b0, 3'd2);                       // empty fill
    push_op(8'hAB, 1'b0, 3'd2);
    push_op(vdp_pkg::OP_COPY_FLAG | 8'd1, 1'b0, 3'd2);
    push_op(8'hFF, 1'b0, 3'd2);
    push_op(8'h7F, 1'b0, 3'd2);                      // longest skip ends column 0
    push_op(8'd0, 1'b0, 3'd2);                       // empty column
    push_op(8'd2, 1'b0, 3'd2);
    push_op(vdp_pkg::OP_FILL, 1'b0, 3'd2);
    push_op(8'hFF, 1'b0, 3'd2);                      // fill past the frame height
    push_op(8'h00, 1'b0, 3'd2);
    push_op(vdp_pkg::OP_COPY_FLAG, 1'b0, 3'd2);      // zero-length copy
    push_op(8'd1, 1'b0, 3'd2);
    push_op(vdp_pkg::OP_COPY_FLAG | 8'd2, 1'b0, 3'd2);
    push_op(8'h11, 1'b0, 3'd2);
    push_op(8'd1, 1'b1, 3'd0);                       // restart on plane 0, abandon the copy
    push_op(vdp_pkg::OP_COPY_FLAG | 8'd2, 1'b0, 3'd0);
    push_op(8'h00, 1'b0, 3'd0);
    push_op(8'hFF, 1'b0, 3'd0);
    push_op(8'd1, 1'b1, 3'd7);                       // plane beyond num_planes
    push_op(vdp_pkg::OP_COPY_FLAG | 8'd1, 1'b0, 3'd7);
    push_op(8'h42, 1'b0, 3'd7);
    gen_random(SEG_BYTES);

    // Small, large, saturating and odd configurations
    run_segment(PACE_SLOW_SINK, 2, 1, 1);
    run_segment(PACE_SLOW_SOURCE, 256, 8, 1024);
    run_segment(PACE_SLOW_SOURCE, 3, 3, 60);
    run_segment(PACE_FREE, 511, 15, 2047);
    run_segment(PACE_FREE, 0, 0, 0);
    run_segment(PACE_FREE, 17, 2, 37);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
